// ===== design/plb_pkg.sv =====
// shared types and constants for the positional list buffer
package plb_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = 5;
    localparam int DW    = 32;
    localparam int CMPW  = ((PW > CW) ? PW : CW) + 1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;

    typedef logic [AW-1:0]        t_addr;
    typedef logic signed [DW-1:0] t_data;

    typedef struct packed {
        logic [1:0]          operation;
        logic [PW-1:0]       position;
        logic signed [DW-1:0] value;
    } t_req;

    typedef struct packed {
        logic                 status;
        logic signed [DW-1:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        t_addr raddr;
    } t_mem_cmd;

endpackage

// ===== design/positional_list_buffer.sv =====
// positional list buffer top level: request checks, shift sequencer and storage
//
// Holds an ordered list of up to 16 signed 32-bit words addressed by 1-based
// position. A request (operation, position, value) is taken at a rising edge
// with start high and busy low. Insert places the value before the position,
// delete removes the entry there, get reads it. Refused requests give status
// 1 and leave the list alone.
// Each request gives exactly one response, shown on o_rsp for one cycle with
// o_valid high; the receiver cannot stall it. busy falls in that same cycle.
// An error, an append or a delete of the last entry is answered straight from
// the idle state. A get first reads storage (S_GET_READ). An insert moves each
// entry from the tail down to the position up one place (S_INS_SHIFT) and then
// writes the value (S_INS_PUT); a delete moves each later entry down one place
// (S_DEL_SHIFT); the single port pair reads one entry and writes one per cycle.
// Reset clears the state, the entry count and o_valid; storage is not cleared
// and what it holds beyond the count is never used.
module positional_list_buffer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  plb_pkg::t_req i_req,
    output logic          o_valid,
    output plb_pkg::t_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_GET_READ
    } t_state;

    t_state                r_state;
    plb_pkg::t_req         r_req;
    logic [plb_pkg::CW-1:0] r_count;
    plb_pkg::t_addr        r_ptr;
    logic                  r_valid;
    plb_pkg::t_rsp         r_rsp;

    plb_pkg::t_mem_cmd     n_cmd;
    plb_pkg::t_data        mem_rdata;

    logic [plb_pkg::CMPW-1:0] pos_x;
    logic [plb_pkg::CMPW-1:0] cnt_x;
    logic                     pos_nz;
    logic                     ins_ok;
    logic                     rd_ok;
    logic                     ins_append;
    logic                     del_tail;
    plb_pkg::t_addr           pos_m1;
    plb_pkg::t_addr           cnt_m1;
    plb_pkg::t_addr           r_pos_m1;
    logic                     accept;

    assign accept     = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign pos_x      = plb_pkg::CMPW'(i_req.position);
    assign cnt_x      = plb_pkg::CMPW'(r_count);
    assign pos_nz     = (i_req.position != '0);
    assign ins_ok     = (cnt_x < plb_pkg::CMPW'(plb_pkg::DEPTH)) && pos_nz
                        && (pos_x <= cnt_x + plb_pkg::CMPW'(1));
    assign rd_ok      = pos_nz && (pos_x <= cnt_x);
    assign ins_append = (pos_x == cnt_x + plb_pkg::CMPW'(1));
    assign del_tail   = (pos_x == cnt_x);
    assign pos_m1     = plb_pkg::AW'(i_req.position - 1'b1);
    assign cnt_m1     = plb_pkg::AW'(r_count - 1'b1);
    assign r_pos_m1   = plb_pkg::AW'(r_req.position - 1'b1);

    // memory port control
    always_comb begin
        n_cmd = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.operation)
                        plb_pkg::OP_INSERT: begin
                            if (ins_ok && ins_append) begin
                                n_cmd.we    = 1'b1;
                                n_cmd.waddr = pos_m1;
                                n_cmd.wdata = i_req.value;
                            end else begin
                                n_cmd.raddr = cnt_m1;
                            end
                        end
                        plb_pkg::OP_DELETE: n_cmd.raddr = plb_pkg::AW'(i_req.position);
                        default:            n_cmd.raddr = pos_m1;
                    endcase
                end
            end
            S_INS_SHIFT: begin
                n_cmd.we    = 1'b1;
                n_cmd.waddr = r_ptr + 1'b1;
                n_cmd.wdata = mem_rdata;
                n_cmd.raddr = r_ptr - 1'b1;
            end
            S_INS_PUT: begin
                n_cmd.we    = 1'b1;
                n_cmd.waddr = r_pos_m1;
                n_cmd.wdata = r_req.value;
            end
            S_DEL_SHIFT: begin
                n_cmd.we    = 1'b1;
                n_cmd.waddr = r_ptr - 1'b1;
                n_cmd.wdata = mem_rdata;
                n_cmd.raddr = r_ptr + 1'b1;
            end
            default: begin
                n_cmd.raddr = r_pos_m1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req <= i_req;
                        r_rsp <= '{status: 1'b1, read_value: '0};
                        unique case (i_req.operation)
                            plb_pkg::OP_INSERT: begin
                                if (!ins_ok) begin
                                    r_valid <= 1'b1;
                                end else if (ins_append) begin
                                    r_count <= r_count + 1'b1;
                                    r_rsp   <= '{status: 1'b0, read_value: '0};
                                    r_valid <= 1'b1;
                                end else begin
                                    r_ptr   <= cnt_m1;
                                    r_state <= S_INS_SHIFT;
                                end
                            end
                            plb_pkg::OP_DELETE: begin
                                if (!rd_ok) begin
                                    r_valid <= 1'b1;
                                end else if (del_tail) begin
                                    r_count <= r_count - 1'b1;
                                    r_rsp   <= '{status: 1'b0, read_value: '0};
                                    r_valid <= 1'b1;
                                end else begin
                                    r_ptr   <= plb_pkg::AW'(i_req.position);
                                    r_state <= S_DEL_SHIFT;
                                end
                            end
                            plb_pkg::OP_GET: begin
                                if (!rd_ok) begin
                                    r_valid <= 1'b1;
                                end else begin
                                    r_state <= S_GET_READ;
                                end
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_INS_SHIFT: begin
                    if (r_ptr == r_pos_m1) begin
                        r_state <= S_INS_PUT;
                    end else begin
                        r_ptr <= r_ptr - 1'b1;
                    end
                end
                S_INS_PUT: begin
                    r_count <= r_count + 1'b1;
                    r_rsp   <= '{status: 1'b0, read_value: '0};
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DEL_SHIFT: begin
                    if (r_ptr == cnt_m1) begin
                        r_count <= r_count - 1'b1;
                        r_rsp   <= '{status: 1'b0, read_value: '0};
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_GET_READ: begin
                    r_rsp   <= '{status: 1'b0, read_value: mem_rdata};
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    plb_mem u_mem (
        .i_clk   (i_clk),
        .i_cmd   (n_cmd),
        .o_rdata (mem_rdata)
    );

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== design/plb_mem.sv =====
// list storage: one write port, one registered read port
module plb_mem (
    input  logic              i_clk,
    input  plb_pkg::t_mem_cmd i_cmd,
    output plb_pkg::t_data    o_rdata
);

    plb_pkg::t_data r_mem [plb_pkg::DEPTH];
    plb_pkg::t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/positional_list_buffer_tb.sv =====
// self-checking testbench for the positional list buffer: directed, full-list and random requests
`timescale 1ns / 100ps

module positional_list_buffer_tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 250000;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    plb_pkg::t_req  i_req   = '0;
    logic           busy;
    logic           o_valid;
    plb_pkg::t_rsp  o_rsp;

    plb_pkg::t_data list_words [plb_pkg::DEPTH];
    int             list_count;
    plb_pkg::t_rsp  pending_rsp [$];

    bit    no_idle;
    int    cycle_count;
    int    mismatches;
    int    rsp_checked;
    int    n_insert, n_delete, n_get, n_refused, n_full_hits;

    positional_list_buffer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_rsp.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic plb_pkg::t_rsp apply_to_list(plb_pkg::t_req r);
        plb_pkg::t_rsp rsp;
        int            p;
        rsp.status     = 1'b1;
        rsp.read_value = '0;
        p = int'(r.position);
        case (r.operation)
            plb_pkg::OP_INSERT: begin
                if (list_count == plb_pkg::DEPTH)
                    n_full_hits++;
                if (list_count < plb_pkg::DEPTH && p >= 1 && p <= list_count + 1) begin
                    for (int k = list_count; k > p - 1; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[p - 1] = r.value;
                    list_count++;
                    rsp.status = 1'b0;
                end
            end
            plb_pkg::OP_DELETE: begin
                if (p >= 1 && p <= list_count) begin
                    for (int k = p - 1; k + 1 < list_count; k++)
                        list_words[k] = list_words[k + 1];
                    list_count--;
                    rsp.status = 1'b0;
                end
            end
            plb_pkg::OP_GET: begin
                if (p >= 1 && p <= list_count) begin
                    rsp.read_value = list_words[p - 1];
                    rsp.status     = 1'b0;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // holds start across back-to-back requests; lowers it only for an idle gap
    task automatic issue_request(plb_pkg::t_req r);
        plb_pkg::t_rsp exp_rsp;
        int            gap;
        if (!no_idle && $urandom_range(99) < 35) begin
            gap = $urandom_range(6, 1);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        exp_rsp = apply_to_list(r);
        pending_rsp.push_back(exp_rsp);
        case (r.operation)
            plb_pkg::OP_INSERT: n_insert++;
            plb_pkg::OP_DELETE: n_delete++;
            plb_pkg::OP_GET:    n_get++;
            default:            ;
        endcase
        if (exp_rsp.status)
            n_refused++;
    endtask

    task automatic send(logic [1:0] op, int pos, plb_pkg::t_data val);
        plb_pkg::t_req r;
        r.operation = op;
        r.position  = pos[plb_pkg::PW-1:0];
        r.value     = val;
        issue_request(r);
    endtask

    function automatic plb_pkg::t_data random_word();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return plb_pkg::t_data'($urandom);
        endcase
    endfunction

    function automatic plb_pkg::t_req random_request(int ins_pct, int del_pct);
        plb_pkg::t_req r;
        int            sel;
        sel = $urandom_range(99);
        if (sel < 3)
            r.operation = OP_UNUSED;
        else if (sel < 3 + ins_pct)
            r.operation = plb_pkg::OP_INSERT;
        else if (sel < 3 + ins_pct + del_pct)
            r.operation = plb_pkg::OP_DELETE;
        else
            r.operation = plb_pkg::OP_GET;
        if ($urandom_range(99) < 85 && r.operation == plb_pkg::OP_INSERT)
            r.position = plb_pkg::PW'($urandom_range(list_count + 1, 1));
        else if ($urandom_range(99) < 85 && list_count > 0)
            r.position = plb_pkg::PW'($urandom_range(list_count, 1));
        else
            r.position = plb_pkg::PW'($urandom_range(31, 0));
        r.value = random_word();
        return r;
    endfunction

    always @(posedge i_clk) begin
        plb_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch($sformatf("response with none pending: status %0b value %0d",
                                          o_rsp.status, o_rsp.read_value));
            end else begin
                exp_rsp = pending_rsp.pop_front();
                rsp_checked++;
                if (o_rsp.status !== exp_rsp.status)
                    report_mismatch($sformatf("status %b, expected %b",
                                              o_rsp.status, exp_rsp.status));
                if (o_rsp.read_value !== exp_rsp.read_value)
                    report_mismatch($sformatf("read_value %0d, expected %0d",
                                              o_rsp.read_value, exp_rsp.read_value));
            end
        end
    end

    task automatic test_edge_cases();
        send(plb_pkg::OP_GET,    1,  32'sd5);
        send(plb_pkg::OP_DELETE, 1,  32'sd5);
        send(plb_pkg::OP_INSERT, 0,  32'sd7);
        send(plb_pkg::OP_INSERT, 2,  32'sd7);
        send(plb_pkg::OP_INSERT, 1,  32'sh8000_0000);
        send(plb_pkg::OP_INSERT, 2,  32'sh7fff_ffff);
        send(plb_pkg::OP_INSERT, 1,  -32'sd1);
        send(plb_pkg::OP_INSERT, 2,  32'sh1234_5678);
        send(plb_pkg::OP_GET,    1,  '0);
        send(plb_pkg::OP_GET,    2,  '0);
        send(plb_pkg::OP_GET,    4,  '0);
        send(plb_pkg::OP_GET,    5,  '0);
        send(plb_pkg::OP_GET,    0,  '0);
        send(plb_pkg::OP_GET,    31, '0);
        send(OP_UNUSED,          1,  32'sh5555_aaaa);
        send(plb_pkg::OP_DELETE, 5,  '0);
        send(plb_pkg::OP_DELETE, 2,  '0);
        send(plb_pkg::OP_DELETE, 3,  '0);
        send(plb_pkg::OP_GET,    2,  '0);
    endtask

    task automatic test_full_list();
        while (list_count < plb_pkg::DEPTH)
            send(plb_pkg::OP_INSERT, $urandom_range(list_count + 1, 1), random_word());
        send(plb_pkg::OP_INSERT, 1,  32'sd99);
        send(plb_pkg::OP_INSERT, plb_pkg::DEPTH + 1, 32'sd99);
        send(plb_pkg::OP_GET,    plb_pkg::DEPTH, '0);
        send(plb_pkg::OP_GET,    plb_pkg::DEPTH + 1, '0);
        send(plb_pkg::OP_DELETE, 1,  '0);
        send(plb_pkg::OP_INSERT, 1,  32'sh0f0f_0f0f);
        send(plb_pkg::OP_DELETE, plb_pkg::DEPTH, '0);
        while (list_count > 0)
            send(plb_pkg::OP_DELETE, $urandom_range(list_count, 1), '0);
    endtask

    task automatic test_random_traffic(int n_items);
        int ins_pct, del_pct;
        for (int i = 0; i < n_items; i++) begin
            case ((i / 60) % 3)
                0: begin ins_pct = 60; del_pct = 12; end
                1: begin ins_pct = 15; del_pct = 55; end
                default: begin ins_pct = 32; del_pct = 32; end
            endcase
            issue_request(random_request(ins_pct, del_pct));
        end
    endtask

    task automatic test_steady_burst(int n_items);
        no_idle = 1'b1;
        for (int i = 0; i < n_items; i++)
            issue_request(random_request(35, 30));
        no_idle = 1'b0;
    endtask

    initial begin
        list_count = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_full_list();
        test_random_traffic(1100);
        test_steady_burst(250);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);

        $display("requests: %0d insert, %0d delete, %0d get, %0d refused, %0d full-list inserts",
                 n_insert, n_delete, n_get, n_refused, n_full_hits);
        $display("responses checked: %0d, mismatches: %0d", rsp_checked, mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
